@@ rtl/core/nrc_pkg.sv @@
// Shared types, constants and checksum helpers for the NAT rewrite checksum core.
package nrc_pkg;

  localparam int unsigned NSTG    = 4;
  localparam int unsigned C32_STG = 3;
  localparam logic [15:0] MASK16  = 16'hffff;

  typedef struct packed {
    logic        is_forward;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
    logic        l4_present;
    logic [31:0] target_ip;
    logic [15:0] target_port;
    logic [47:0] target_mac;
    logic [47:0] old_dst_mac;
  } nrc_in_t;

  typedef struct packed {
    logic [31:0] new_src_ip;
    logic [31:0] new_dst_ip;
    logic [15:0] new_src_port;
    logic [15:0] new_dst_port;
    logic [15:0] new_ip_checksum;
    logic [15:0] new_l4_checksum;
    logic [47:0] new_dst_mac;
    logic [47:0] new_src_mac;
  } nrc_out_t;

  typedef struct packed {
    logic [31:0] new_src_ip;
    logic [31:0] new_dst_ip;
    logic [15:0] new_src_port;
    logic [15:0] new_dst_port;
    logic [47:0] new_dst_mac;
    logic [47:0] new_src_mac;
    logic [15:0] l4_checksum;
    logic        l4_present;
    logic [15:0] prev_port;
    logic [15:0] target_port;
  } nrc_pass_t;

  typedef struct packed {
    logic [C32_STG-1:0] en;
  } nrc_ctl_t;

  // 32-bit add with end-around carry
  function automatic logic [31:0] eac32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31:0] + {31'b0, s[32]};
  endfunction

  // 16-bit add with end-around carry
  function automatic logic [15:0] eac16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

@@ rtl/core/nrc_csum32.sv @@
// Three-stage incremental checksum update for a 32-bit field replacement.
module nrc_csum32
  import nrc_pkg::*;
(
  input  logic        clk,
  input  nrc_ctl_t    ctl,
  input  logic [15:0] sum,
  input  logic [31:0] from_val,
  input  logic [31:0] to_val,
  output logic [15:0] ck
);

  logic [31:0] t_r, t_nxt;
  logic [31:0] to_r;
  logic [31:0] u_r, u_nxt;
  logic [15:0] ck_r, ck_nxt;
  logic [16:0] v1;
  logic [15:0] v2;

  assign t_nxt = eac32({MASK16, ~sum}, ~from_val);
  assign u_nxt = eac32(t_r, to_r);

  always_comb begin
    v1     = {1'b0, u_r[15:0]} + {1'b0, u_r[31:16]};
    v2     = v1[15:0] + {15'b0, v1[16]};
    ck_nxt = ~v2;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      t_r  <= t_nxt;
      to_r <= to_val;
    end
    if (ctl.en[1]) begin
      u_r <= u_nxt;
    end
    if (ctl.en[2]) begin
      ck_r <= ck_nxt;
    end
  end

  assign ck = ck_r;

endmodule

@@ rtl/core/nrc_csum16.sv @@
// Port update of the L4 checksum and bypass when no L4 checksum is carried.
module nrc_csum16
  import nrc_pkg::*;
(
  input  logic [15:0] sum,
  input  logic [15:0] from_val,
  input  logic [15:0] to_val,
  input  logic        present,
  input  logic [15:0] orig,
  output logic [15:0] ck
);

  logic [15:0] t;
  logic [15:0] r;

  always_comb begin
    t  = eac16(~sum, ~from_val);
    r  = ~eac16(t, to_val);
    ck = present ? r : orig;
  end

endmodule

@@ rtl/core/nat_rewrite_incremental_checksum_core.sv @@
// Top level of the NAT header rewrite core with incremental checksum update.
//
// Input channel in_valid/in_stall/in_data carries one parsed header tuple and
// its translation target per beat; out_valid/out_stall/out_data returns one
// rewritten tuple per beat, in order.
// Throughput: one beat per cycle while out_stall is low. The four stages are:
// end-around-carry subtract of the old address, end-around-carry add of the
// new address, double fold, then the 16-bit port update of the L4 checksum
// into the output register.
// Each stage has its own valid bit and loads whenever it is empty or its
// successor takes its beat, so bubbles are squeezed out under stall.
// Reset clears all valid bits; payload registers are not reset.
// When out_stall is high the output beat holds; in_stall rises only once all
// four stages hold a beat, and no beat is lost or repeated.
module nat_rewrite_incremental_checksum_core
  import nrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  nrc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output nrc_out_t out_data
);

  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG-1:0] en;
  nrc_ctl_t        ctl;
  nrc_pass_t       pass_r [C32_STG];
  nrc_pass_t       pass_nxt;
  nrc_out_t        out_r, out_nxt;
  logic [31:0]     old_ip;
  logic [15:0]     ip_ck;
  logic [15:0]     l4_ck32;
  logic [15:0]     l4_ck;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt    = {v_r[NSTG-2:0], in_valid};
    ctl.en   = en[C32_STG-1:0];
  end

  assign in_stall = !en[0];

  always_comb begin
    old_ip               = in_data.is_forward ? in_data.dst_ip : in_data.src_ip;
    pass_nxt.new_src_ip  = in_data.is_forward ? in_data.src_ip : in_data.target_ip;
    pass_nxt.new_dst_ip  = in_data.is_forward ? in_data.target_ip : in_data.dst_ip;
    pass_nxt.new_src_port = in_data.is_forward ? in_data.src_port : in_data.target_port;
    pass_nxt.new_dst_port = in_data.is_forward ? in_data.target_port : in_data.dst_port;
    pass_nxt.new_dst_mac = in_data.target_mac;
    pass_nxt.new_src_mac = in_data.old_dst_mac;
    pass_nxt.l4_checksum = in_data.l4_checksum;
    pass_nxt.l4_present  = in_data.l4_present;
    pass_nxt.prev_port   = in_data.is_forward ? in_data.dst_port : in_data.src_port;
    pass_nxt.target_port = in_data.target_port;
  end

  nrc_csum32 u_ip_ck (
    .clk      (clk),
    .ctl      (ctl),
    .sum      (in_data.ip_checksum),
    .from_val (old_ip),
    .to_val   (in_data.target_ip),
    .ck       (ip_ck)
  );

  nrc_csum32 u_l4_ck (
    .clk      (clk),
    .ctl      (ctl),
    .sum      (in_data.l4_checksum),
    .from_val (old_ip),
    .to_val   (in_data.target_ip),
    .ck       (l4_ck32)
  );

  nrc_csum16 u_port_ck (
    .sum      (l4_ck32),
    .from_val (pass_r[C32_STG-1].prev_port),
    .to_val   (pass_r[C32_STG-1].target_port),
    .present  (pass_r[C32_STG-1].l4_present),
    .orig     (pass_r[C32_STG-1].l4_checksum),
    .ck       (l4_ck)
  );

  always_comb begin
    out_nxt.new_src_ip      = pass_r[C32_STG-1].new_src_ip;
    out_nxt.new_dst_ip      = pass_r[C32_STG-1].new_dst_ip;
    out_nxt.new_src_port    = pass_r[C32_STG-1].new_src_port;
    out_nxt.new_dst_port    = pass_r[C32_STG-1].new_dst_port;
    out_nxt.new_ip_checksum = ip_ck;
    out_nxt.new_l4_checksum = l4_ck;
    out_nxt.new_dst_mac     = pass_r[C32_STG-1].new_dst_mac;
    out_nxt.new_src_mac     = pass_r[C32_STG-1].new_src_mac;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pass_r[0] <= pass_nxt;
    end
    for (int i = 1; i < C32_STG; i++) begin
      if (en[i]) begin
        pass_r[i] <= pass_r[i-1];
      end
    end
    if (en[NSTG-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // input backs up only with every stage full and the output stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_stall))
    else $error("in_stall with a free pipeline stage");

  // a beat handed to stage two is held there on the next edge
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && en[1]) |=> v_r[1])
    else $error("beat lost between stage one and two");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("valid bits set after reset");
`endif

endmodule

@@ tb/nat_rewrite_incremental_checksum_core_tb.sv @@
// Self-checking testbench for the NAT header rewrite core with incremental checksum update.
module nat_rewrite_incremental_checksum_core_tb;
  import nrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_HDRS = 1350;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 27;
  localparam int unsigned QUIET_LO    = 400;
  localparam int unsigned QUIET_HI    = 700;
  localparam int unsigned HOLD_AT     = 900;
  localparam int unsigned HOLD_CYCLES = 80;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  nrc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  nrc_out_t out_data;

  nrc_in_t  hdr_pending[$];
  nrc_out_t rewrite_expected[$];
  nrc_out_t want;
  logic     in_beat     = 1'b0;
  int       sent_cnt    = 0;
  int       rcv_cnt     = 0;
  int       mismatches  = 0;
  int       hold_left   = 0;
  logic     hold_done   = 1'b0;
  int       cycle_cnt   = 0;

  nat_rewrite_incremental_checksum_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] ones_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31:0] + {31'b0, s[32]};
  endfunction

  function automatic logic [15:0] ones_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  function automatic logic [15:0] csum_swap32(input logic [15:0] sum, input logic [31:0] from_v,
                                              input logic [31:0] to_v);
    logic [31:0] v;
    v = ones_add32({16'hffff, ~sum}, ~from_v);
    v = ones_add32(v, to_v);
    v = {16'b0, v[15:0]} + {16'b0, v[31:16]};
    v = {16'b0, v[15:0]} + {16'b0, v[31:16]};
    return ~v[15:0];
  endfunction

  function automatic logic [15:0] csum_swap16(input logic [15:0] sum, input logic [15:0] from_v,
                                              input logic [15:0] to_v);
    return ~ones_add16(ones_add16(~sum, ~from_v), to_v);
  endfunction

  function automatic nrc_out_t nat_rewrite_predict(input nrc_in_t h);
    nrc_out_t    r;
    logic [31:0] old_ip;
    logic [15:0] prev_port;
    logic [15:0] l4;
    r.new_src_ip   = h.src_ip;
    r.new_dst_ip   = h.dst_ip;
    r.new_src_port = h.src_port;
    r.new_dst_port = h.dst_port;
    if (h.is_forward) begin
      old_ip         = h.dst_ip;
      prev_port      = h.dst_port;
      r.new_dst_ip   = h.target_ip;
      r.new_dst_port = h.target_port;
    end else begin
      old_ip         = h.src_ip;
      prev_port      = h.src_port;
      r.new_src_ip   = h.target_ip;
      r.new_src_port = h.target_port;
    end
    r.new_ip_checksum = csum_swap32(h.ip_checksum, old_ip, h.target_ip);
    l4 = h.l4_checksum;
    if (h.l4_present) begin
      l4 = csum_swap32(l4, old_ip, h.target_ip);
      l4 = csum_swap16(l4, prev_port, h.target_port);
    end
    r.new_l4_checksum = l4;
    r.new_dst_mac     = h.target_mac;
    r.new_src_mac     = h.old_dst_mac;
    return r;
  endfunction

  function automatic nrc_in_t mk_hdr(input logic fwd, input logic [31:0] sip,
                                     input logic [31:0] dip, input logic [15:0] sp,
                                     input logic [15:0] dp, input logic [15:0] ipck,
                                     input logic [15:0] l4ck, input logic l4p,
                                     input logic [31:0] tip, input logic [15:0] tp,
                                     input logic [47:0] tmac, input logic [47:0] omac);
    nrc_in_t h;
    h.is_forward  = fwd;
    h.src_ip      = sip;
    h.dst_ip      = dip;
    h.src_port    = sp;
    h.dst_port    = dp;
    h.ip_checksum = ipck;
    h.l4_checksum = l4ck;
    h.l4_present  = l4p;
    h.target_ip   = tip;
    h.target_port = tp;
    h.target_mac  = tmac;
    h.old_dst_mac = omac;
    return h;
  endfunction

  function automatic nrc_in_t rand_hdr();
    nrc_in_t h;
    int      mode;
    h.is_forward  = 1'($urandom_range(0, 1));
    h.src_ip      = $urandom;
    h.dst_ip      = $urandom;
    h.src_port    = 16'($urandom);
    h.dst_port    = 16'($urandom);
    h.ip_checksum = 16'($urandom);
    h.l4_checksum = 16'($urandom);
    h.l4_present  = 1'($urandom_range(0, 1));
    h.target_ip   = $urandom;
    h.target_port = 16'($urandom);
    h.target_mac  = {16'($urandom), 32'($urandom)};
    h.old_dst_mac = {16'($urandom), 32'($urandom)};
    mode = $urandom_range(0, 15);
    if (mode == 0) begin
      // translation target equals the field it replaces
      h.target_ip   = h.is_forward ? h.dst_ip : h.src_ip;
      h.target_port = h.is_forward ? h.dst_port : h.src_port;
    end else if (mode == 1) begin
      h.ip_checksum = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      h.l4_checksum = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    end else if (mode == 2) begin
      // L4 update that lands on zero
      h.is_forward  = 1'b1;
      h.dst_ip      = '0;
      h.target_ip   = '0;
      h.dst_port    = '0;
      h.l4_present  = 1'b1;
      h.l4_checksum = 16'($urandom_range(0, 16'hfffe));
      h.target_port = h.l4_checksum;
    end
    return h;
  endfunction

  task automatic cmp_field(input string name, input logic [47:0] exp_v, input logic [47:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (hdr_pending.size() > 0 &&
          ((sent_cnt >= QUIET_LO && sent_cnt < QUIET_HI) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data  <= hdr_pending.pop_front();
        in_valid <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_beat <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      rewrite_expected.push_back(nat_rewrite_predict(in_data));
  end

  // receiver, with one long hold-off to back the pipe up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && rcv_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(rcv_cnt >= QUIET_LO && rcv_cnt < QUIET_HI) &&
                   ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rewrite_expected.size() == 0) begin
        $error("unexpected output beat: %h", out_data);
        mismatches++;
      end else begin
        want = rewrite_expected.pop_front();
        cmp_field("new_src_ip", 48'(want.new_src_ip), 48'(out_data.new_src_ip));
        cmp_field("new_dst_ip", 48'(want.new_dst_ip), 48'(out_data.new_dst_ip));
        cmp_field("new_src_port", 48'(want.new_src_port), 48'(out_data.new_src_port));
        cmp_field("new_dst_port", 48'(want.new_dst_port), 48'(out_data.new_dst_port));
        cmp_field("new_ip_checksum", 48'(want.new_ip_checksum),
                  48'(out_data.new_ip_checksum));
        cmp_field("new_l4_checksum", 48'(want.new_l4_checksum),
                  48'(out_data.new_l4_checksum));
        cmp_field("new_dst_mac", want.new_dst_mac, out_data.new_dst_mac);
        cmp_field("new_src_mac", want.new_src_mac, out_data.new_src_mac);
      end
      rcv_cnt++;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** nat_rewrite_incremental_checksum_core: FAILED **");
    $finish;
  end

  initial begin
    hdr_pending.push_back(mk_hdr(1'b1, '0, '0, '0, '0, '0, '0, 1'b1, '0, '0, '0, '0));
    hdr_pending.push_back(mk_hdr(1'b0, '0, '0, '0, '0, '0, '0, 1'b1, '0, '0, '0, '0));
    hdr_pending.push_back(mk_hdr(1'b1, '1, '1, '1, '1, '1, '1, 1'b1, '1, '1, '1, '1));
    hdr_pending.push_back(mk_hdr(1'b0, '1, '1, '1, '1, '1, '1, 1'b0, '1, '1, '1, '1));
    hdr_pending.push_back(mk_hdr(1'b1, 32'h0a000001, 32'hc0a80001, 16'd40000, 16'd80,
                                 16'hb1e6, 16'h1c46, 1'b0, 32'h0a010203, 16'd8080,
                                 48'h020000000001, 48'h0200000000fe));
    hdr_pending.push_back(mk_hdr(1'b0, 32'h0a010203, 32'h0a000001, 16'd8080, 16'd40000,
                                 16'h3c1d, 16'h8a2f, 1'b1, 32'hc0a80001, 16'd80,
                                 48'h001122334455, 48'h66778899aabb));
    hdr_pending.push_back(mk_hdr(1'b1, 32'h01020304, 32'h05060708, 16'h1111, 16'h2222,
                                 16'h0000, 16'hffff, 1'b1, 32'h05060708, 16'h2222,
                                 48'h0, 48'h0));
    hdr_pending.push_back(mk_hdr(1'b0, 32'h01020304, 32'h05060708, 16'h1111, 16'h2222,
                                 16'hffff, 16'h0000, 1'b1, 32'h01020304, 16'h1111,
                                 48'h0, 48'h0));
    hdr_pending.push_back(mk_hdr(1'b1, 32'hdeadbeef, '0, 16'h0101, '0, 16'h4321, 16'h1234,
                                 1'b1, '0, 16'h1234, 48'h123456789abc, 48'hcba987654321));
    hdr_pending.push_back(mk_hdr(1'b1, 32'h7f000001, 32'h80000000, 16'h0001, 16'h8000,
                                 16'h0000, 16'hffff, 1'b1, 32'hffffffff, 16'h7fff,
                                 48'haaaaaaaaaaaa, 48'h555555555555));
    hdr_pending.push_back(mk_hdr(1'b0, 32'hffffffff, 32'h00000000, 16'hffff, 16'h0000,
                                 16'hffff, 16'h0000, 1'b1, 32'h00000000, 16'h0000,
                                 48'h555555555555, 48'haaaaaaaaaaaa));
    hdr_pending.push_back(mk_hdr(1'b1, 32'h00000000, 32'h00000000, 16'h0000, 16'h0000,
                                 16'h1234, 16'h5678, 1'b1, 32'h00000000, 16'hffff,
                                 48'hffffffffffff, 48'h000000000000));
    hdr_pending.push_back(mk_hdr(1'b0, 32'h00000000, 32'hffffffff, 16'h0000, 16'hffff,
                                 16'h9abc, 16'hdef0, 1'b1, 32'hffffffff, 16'h0000,
                                 48'h000000000000, 48'hffffffffffff));
    hdr_pending.push_back(mk_hdr(1'b0, 32'hc0000201, 32'hc6336401, 16'd53, 16'd5353,
                                 16'h0001, 16'hfffe, 1'b0, 32'ha9fe0001, 16'd67,
                                 48'h0180c2000000, 48'h3333000000fb));
    repeat (RANDOM_HDRS) hdr_pending.push_back(rand_hdr());

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (hdr_pending.size() != 0 || in_valid || rewrite_expected.size() != 0)
      @(posedge clk);
    repeat (4 * NSTG) @(posedge clk);
    if (mismatches == 0) begin
      $display("** nat_rewrite_incremental_checksum_core: PASSED **");
    end else begin
      $display("** nat_rewrite_incremental_checksum_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/nrc_pkg.sv
rtl/core/nrc_csum32.sv
rtl/core/nrc_csum16.sv
rtl/core/nat_rewrite_incremental_checksum_core.sv
tb/nat_rewrite_incremental_checksum_core_tb.sv
